// ===== hdl/pkwrm_pkg.sv =====
// Shared types, constants and codes for the per-key write rate monitor.
package pkwrm_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PTR_W         = IDX_W + 1;

  // Field widths
  localparam int KEY_W  = 32;
  localparam int TS_W   = 63;
  localparam int CNT_W  = 32;
  localparam int WL_W   = 40;
  localparam int ALU_W  = 64;
  localparam int CFG_W  = 40;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Register reset values
  localparam logic [WL_W-1:0]  WINDOW_LENGTH_RST   = 40'd50000000;
  localparam logic [CNT_W-1:0] WARN_THRESHOLD_RST  = 32'd10;
  localparam logic [CNT_W-1:0] BLOCK_THRESHOLD_RST = 32'd50;

  // Register indexes
  localparam logic [1:0] CFG_WINDOW_LENGTH   = 2'd0;
  localparam logic [1:0] CFG_WARN_THRESHOLD  = 2'd1;
  localparam logic [1:0] CFG_BLOCK_THRESHOLD = 2'd2;

  typedef enum logic [1:0] {
    VERDICT_ALLOW = 2'd0,
    VERDICT_WARN  = 2'd1,
    VERDICT_BLOCK = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [KEY_W-1:0] source_key;
    logic [TS_W-1:0]  timestamp;
    logic             exempt;
  } in_item_t;

  typedef struct packed {
    verdict_t         verdict;
    logic [CNT_W-1:0] event_count;
    logic [4:0]       entry_index;
  } out_result_t;

  // One stored table entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
    logic [TS_W-1:0]  window_start;
  } entry_t;

  // Shared arithmetic unit
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W:0] sum;
    logic           zero;
    logic           borrow;
  } alu_resp_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WIN,
    ST_EXP,
    ST_INC,
    ST_WARN,
    ST_BLK,
    ST_BLK1,
    ST_FINISH
  } state_t;

endpackage

// ===== hdl/pkwrm_alu.sv =====
// Shared 64-bit add/subtract unit with zero and borrow flags.
module pkwrm_alu
  import pkwrm_pkg::*;
(
  input  alu_req_t  req,
  output alu_resp_t resp
);

  logic [ALU_W:0] sum;

  // Form the sum or difference one bit wider than the operands
  always_comb begin
    unique case (req.op)
      ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
    endcase
  end

  assign resp.sum    = sum;
  assign resp.zero   = (sum[ALU_W-1:0] == '0);
  assign resp.borrow = (req.op == ALU_SUB) & sum[ALU_W];

endmodule

// ===== hdl/pkwrm_table.sv =====
// Key table: entry memory with registered read and reset-cleared valid bits.
module pkwrm_table
  import pkwrm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [IDX_W-1:0]         rd_addr,
  output entry_t                   rd_data,
  input  logic                     wr_en,
  input  logic [IDX_W-1:0]         wr_addr,
  input  entry_t                   wr_data,
  output logic [TABLE_ENTRIES-1:0] valid
);

  entry_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;

  // Write and read the entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Mark written entries valid; clear all at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign valid = valid_r;

endmodule

// ===== hdl/per_key_write_rate_monitor.sv =====
// Top level: sequencer for the per-key write rate monitor.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+----------------------------------
//  input    | start, busy, in_item           | taken when start & !busy
//  result   | out_valid, out_result          | one-cycle strobe, no back-pressure
//  config   | cfg_we, cfg_index, cfg_wdata   | written when cfg_we is high
//
// A tracked item is taken, then the key scan runs through the single registered
// read port of the table (ending early on a hit), then four to six passes go
// through the shared add/subtract unit, and last the entry is written back and
// the result presented. An exempt item goes straight from being taken to its result.
// Reset is synchronous and active low; it clears the valid bits at once, so
// no clearing pass is needed. The receiver cannot stall; busy stays high from
// the cycle after an item is taken until its result strobe.
module per_key_write_rate_monitor
  import pkwrm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_valid,
  output out_result_t      out_result,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  state_t             state_r, state_nxt;
  in_item_t           item_r, item_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_r, free_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TS_W-1:0]    ws_r, ws_nxt;
  logic [ALU_W-1:0]   d_r, d_nxt;
  logic               neg_r, neg_nxt;
  verdict_t           verdict_r, verdict_nxt;

  logic [WL_W-1:0]    wl_r;
  logic [CNT_W-1:0]   warn_r;
  logic [CNT_W-1:0]   block_r;

  alu_req_t           alu_req;
  alu_resp_t          alu_resp;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  entry_t             rd_data;
  logic               wr_en;
  entry_t             wr_data;
  logic [TABLE_ENTRIES-1:0] valid;

  logic               accept;
  logic               cmp_entry_valid;
  logic [IDX_W-1:0]   free_sel;
  logic [31:0]        idx_wide;

  assign accept = start & (state_r == ST_IDLE);

  pkwrm_alu u_alu (
    .req  (alu_req),
    .resp (alu_resp)
  );

  pkwrm_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_data),
    .valid   (valid)
  );

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r    <= WINDOW_LENGTH_RST;
      warn_r  <= WARN_THRESHOLD_RST;
      block_r <= BLOCK_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH:   wl_r    <= cfg_wdata[WL_W-1:0];
        CFG_WARN_THRESHOLD:  warn_r  <= cfg_wdata[CNT_W-1:0];
        CFG_BLOCK_THRESHOLD: block_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the sequencer state and scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      free_found_r <= free_found_nxt;
    end
  end

  // Hold item payload and working values
  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    ptr_r     <= ptr_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    free_r    <= free_nxt;
    idx_r     <= idx_nxt;
    cnt_r     <= cnt_nxt;
    ws_r      <= ws_nxt;
    d_r       <= d_nxt;
    neg_r     <= neg_nxt;
    verdict_r <= verdict_nxt;
  end

  assign cmp_entry_valid = valid[cmp_idx_r];

  // Lowest free entry seen so far, including the one under compare; else entry 0
  always_comb begin
    if (free_found_r) begin
      free_sel = free_r;
    end else if (!cmp_entry_valid) begin
      free_sel = cmp_idx_r;
    end else begin
      free_sel = '0;
    end
  end

  // Sequence the scan and the arithmetic passes
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    ptr_nxt        = ptr_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    ws_nxt         = ws_r;
    d_nxt          = d_r;
    neg_nxt        = neg_r;
    verdict_nxt    = verdict_r;
    rd_en          = 1'b0;
    rd_addr        = ptr_r[IDX_W-1:0];
    wr_en          = 1'b0;
    alu_req.op     = ALU_SUB;
    alu_req.a      = '0;
    alu_req.b      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt       = in_item;
          ptr_nxt        = '0;
          free_found_nxt = 1'b0;
          if (in_item.exempt) begin
            verdict_nxt = VERDICT_ALLOW;
            cnt_nxt     = '0;
            idx_nxt     = '0;
            state_nxt   = ST_FINISH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read while comparing the entry read last cycle
        if (ptr_r < PTR_W'(TABLE_ENTRIES)) begin
          rd_en       = 1'b1;
          ptr_nxt     = ptr_r + PTR_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = ptr_r[IDX_W-1:0];
        end
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(rd_data.key);
        alu_req.b  = ALU_W'(item_r.source_key);
        if (cmp_vld_r) begin
          if (cmp_entry_valid && alu_resp.zero) begin
            // Hit: take the stored entry
            idx_nxt     = cmp_idx_r;
            cnt_nxt     = rd_data.count;
            ws_nxt      = rd_data.window_start;
            cmp_vld_nxt = 1'b0;
            state_nxt   = ST_WIN;
          end else begin
            if (!cmp_entry_valid && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_nxt       = cmp_idx_r;
            end
            if (cmp_idx_r == IDX_W'(TABLE_ENTRIES - 1)) begin
              // Miss: claim an entry and open a fresh window
              idx_nxt     = free_sel;
              cnt_nxt     = '0;
              ws_nxt      = item_r.timestamp;
              cmp_vld_nxt = 1'b0;
              state_nxt   = ST_WIN;
            end
          end
        end
      end

      ST_WIN: begin
        // Time since the window opened, as a signed difference
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(item_r.timestamp);
        alu_req.b  = ALU_W'(ws_r);
        d_nxt      = alu_resp.sum[ALU_W-1:0];
        neg_nxt    = alu_resp.borrow;
        state_nxt  = ST_EXP;
      end

      ST_EXP: begin
        // Restart the window once it has run out
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(wl_r);
        alu_req.b  = d_r;
        if (!neg_r && alu_resp.borrow) begin
          cnt_nxt = '0;
          ws_nxt  = item_r.timestamp;
        end
        state_nxt = ST_INC;
      end

      ST_INC: begin
        // Count the item, saturating
        alu_req.op = ALU_ADD;
        alu_req.a  = ALU_W'(cnt_r);
        alu_req.b  = ALU_W'(1);
        cnt_nxt    = alu_resp.sum[CNT_W] ? CNT_MAX : alu_resp.sum[CNT_W-1:0];
        state_nxt  = ST_WARN;
      end

      ST_WARN: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(cnt_r);
        alu_req.b  = ALU_W'(warn_r);
        if (alu_resp.zero) begin
          verdict_nxt = VERDICT_WARN;
          state_nxt   = ST_FINISH;
        end else begin
          state_nxt = ST_BLK;
        end
      end

      ST_BLK: begin
        // Block when the count is above the block threshold
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(block_r);
        alu_req.b  = ALU_W'(cnt_r);
        if (alu_resp.borrow) begin
          verdict_nxt = VERDICT_BLOCK;
          state_nxt   = ST_BLK1;
        end else begin
          verdict_nxt = VERDICT_ALLOW;
          state_nxt   = ST_FINISH;
        end
      end

      ST_BLK1: begin
        // Pin the count just above the threshold and restart the window
        alu_req.op = ALU_ADD;
        alu_req.a  = ALU_W'(block_r);
        alu_req.b  = ALU_W'(1);
        cnt_nxt    = alu_resp.sum[CNT_W] ? CNT_MAX : alu_resp.sum[CNT_W-1:0];
        ws_nxt     = item_r.timestamp;
        state_nxt  = ST_FINISH;
      end

      ST_FINISH: begin
        // Write back the entry (not for an exempt item) and present the result
        wr_en     = !item_r.exempt;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign wr_data.key          = item_r.source_key;
  assign wr_data.count        = cnt_r;
  assign wr_data.window_start = ws_r;

  assign idx_wide = 32'(idx_r);

  assign busy                   = (state_r != ST_IDLE);
  assign out_valid              = (state_r == ST_FINISH);
  assign out_result.verdict     = verdict_r;
  assign out_result.event_count = cnt_r;
  assign out_result.entry_index = idx_wide[4:0];

  // A taken item makes the block busy in the next cycle
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy
  ) else $error("block not busy after taking an item");

  // Each result is strobed for a single cycle and then the block is free
  a_single_strobe: assert property (
    @(posedge clk) disable iff (!rst_n) out_valid |=> (!out_valid && !busy)
  ) else $error("result strobe longer than one cycle");

  // A blocked item reports the count pinned just above the block threshold
  a_block_count: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_valid && out_result.verdict == VERDICT_BLOCK) |->
      (out_result.event_count == ((block_r == CNT_MAX) ? CNT_MAX : block_r + 32'd1))
  ) else $error("blocked count not pinned to threshold plus one");

  // An exempt item reports zero count at entry zero
  a_exempt_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_valid && item_r.exempt) |->
      (out_result.event_count == '0 && out_result.entry_index == '0 &&
       out_result.verdict == VERDICT_ALLOW)
  ) else $error("exempt item result not cleared");

endmodule

// ===== dv/per_key_write_rate_monitor_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the per-key write rate monitor.
module per_key_write_rate_monitor_tb;
  import pkwrm_pkg::*;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  in_item_t         in_item   = '0;
  logic             out_valid;
  out_result_t      out_result;
  logic             cfg_we    = 1'b0;
  logic [1:0]       cfg_index = CFG_WINDOW_LENGTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Mirror of the key table and the registers
  logic             trk_valid [TABLE_ENTRIES];
  logic [KEY_W-1:0] trk_key   [TABLE_ENTRIES];
  logic [CNT_W-1:0] trk_count [TABLE_ENTRIES];
  logic [TS_W-1:0]  trk_start [TABLE_ENTRIES];
  logic [WL_W-1:0]  win_len;
  logic [CNT_W-1:0] warn_lvl;
  logic [CNT_W-1:0] block_lvl;

  in_item_t    pending_events[$];
  out_result_t expected_verdicts[$];
  int          errors   = 0;
  int          gap_left = 0;
  int          idle_pct = 30;

  per_key_write_rate_monitor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Look up or claim an entry, age the window, count the write and rate it
  function automatic out_result_t rate_verdict(in_item_t ev);
    out_result_t      res;
    int               idx;
    logic [63:0]      d;
    logic [CNT_W-1:0] cnt;
    res.verdict     = VERDICT_ALLOW;
    res.event_count = '0;
    res.entry_index = '0;
    if (ev.exempt) return res;
    idx = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (idx < 0 && trk_valid[i] && trk_key[i] == ev.source_key) idx = i;
    if (idx < 0) begin
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (idx < 0 && !trk_valid[i]) idx = i;
      if (idx < 0) idx = 0;
      trk_valid[idx] = 1'b1;
      trk_key[idx]   = ev.source_key;
      trk_count[idx] = '0;
      trk_start[idx] = ev.timestamp;
    end
    // A negative distance never ages the window out
    d = {1'b0, ev.timestamp} - {1'b0, trk_start[idx]};
    if (!d[63] && d > {24'd0, win_len}) begin
      trk_count[idx] = '0;
      trk_start[idx] = ev.timestamp;
    end
    cnt = trk_count[idx];
    if (cnt != CNT_MAX) cnt = cnt + 32'd1;
    trk_count[idx] = cnt;
    // Warn takes priority over block
    if (cnt == warn_lvl) begin
      res.verdict = VERDICT_WARN;
    end else if (cnt > block_lvl) begin
      res.verdict    = VERDICT_BLOCK;
      trk_count[idx] = (block_lvl == CNT_MAX) ? CNT_MAX : block_lvl + 32'd1;
      trk_start[idx] = ev.timestamp;
    end
    res.event_count = trk_count[idx];
    res.entry_index = idx[4:0];
    return res;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 10);
    return $urandom_range(3, 1);
  endfunction

  // Driver: present queued items, hold while busy, idle at random after each
  always @(posedge clk) begin
    logic taken;
    taken = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (taken) begin
        expected_verdicts.push_back(rate_verdict(in_item));
        gap_left = pick_gap();
      end
      if (start && !taken) begin
        // hold the current item
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (pending_events.size() > 0) begin
        in_item <= pending_events.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result strobe with the oldest expectation
  always @(posedge clk) begin
    out_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: verdict %0d event_count %0d entry_index %0d",
               out_result.verdict, out_result.event_count, out_result.entry_index);
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_result.verdict !== want.verdict) begin
          $error("verdict: expected %0d, actual %0d", want.verdict, out_result.verdict);
          errors++;
        end
        if (out_result.event_count !== want.event_count) begin
          $error("event_count: expected %0d, actual %0d",
                 want.event_count, out_result.event_count);
          errors++;
        end
        if (out_result.entry_index !== want.entry_index) begin
          $error("entry_index: expected %0d, actual %0d",
                 want.entry_index, out_result.entry_index);
          errors++;
        end
      end
    end
  end

  task automatic queue_event(input logic [KEY_W-1:0] key, input logic [TS_W-1:0] ts,
                             input logic ex);
    in_item_t ev;
    ev.source_key = key;
    ev.timestamp  = ts;
    ev.exempt     = ex;
    pending_events.push_back(ev);
  endtask

  // Wait until every queued item has been taken and its result checked
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_events.size() != 0 || start || expected_verdicts.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_WINDOW_LENGTH:   win_len   = val[WL_W-1:0];
      CFG_WARN_THRESHOLD:  warn_lvl  = val[CNT_W-1:0];
      CFG_BLOCK_THRESHOLD: block_lvl = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [WL_W-1:0] wl, input logic [CNT_W-1:0] warn,
                          input logic [CNT_W-1:0] blk);
    wait_drained();
    write_reg(CFG_WINDOW_LENGTH, CFG_W'(wl));
    write_reg(CFG_WARN_THRESHOLD, CFG_W'(warn));
    write_reg(CFG_BLOCK_THRESHOLD, CFG_W'(blk));
  endtask

  // Random writes from a pool of keys, with timestamps that mostly creep
  // forward inside the window and now and then expire it, step back or jump
  task automatic run_phase(input logic [WL_W-1:0] wl, input logic [CNT_W-1:0] warn,
                           input logic [CNT_W-1:0] blk, input int pool_n,
                           input int items, input int idle);
    logic [KEY_W-1:0] key_pool [64];
    logic [KEY_W-1:0] key;
    logic [63:0]      ts;
    logic [63:0]      span;
    logic [63:0]      r64;
    logic [63:0]      back;
    int               pick;
    set_regs(wl, warn, blk);
    idle_pct = idle;
    for (int i = 0; i < pool_n; i++) key_pool[i] = $urandom;
    span = {24'd0, wl} + 64'd1;
    r64  = {$urandom, $urandom};
    case ($urandom_range(2))
      0:       ts = 64'($urandom_range(1000));
      1:       ts = {1'b0, r64[62:0]};
      default: ts = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(1 << 20));
    endcase
    for (int n = 0; n < items; n++) begin
      r64  = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 3) begin
        ts = {1'b0, r64[62:0]};
      end else if (pick < 8) begin
        back = r64 % span;
        ts   = (back > ts) ? 64'd0 : ts - back;
      end else if (pick < 15) begin
        ts = ts + span + r64 % span;
      end else begin
        ts = ts + r64 % (span / 64'd16 + 64'd1);
      end
      // Wrap past the top of the field back to a low time
      if (ts[63]) ts = {24'd0, r64[39:0]};
      if ($urandom_range(31) == 0)
        key = $urandom_range(1) ? '1 : '0;
      else if ($urandom_range(15) == 0)
        key = $urandom;
      else
        key = key_pool[$urandom_range(pool_n - 1)];
      queue_event(key, ts[TS_W-1:0], $urandom_range(9) == 0);
    end
  endtask

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      trk_valid[i] = 1'b0;
      trk_key[i]   = '0;
      trk_count[i] = '0;
      trk_start[i] = '0;
    end
    win_len   = WINDOW_LENGTH_RST;
    warn_lvl  = WARN_THRESHOLD_RST;
    block_lvl = BLOCK_THRESHOLD_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: exempt extremes, claim, hit, expiry, stepping back
    queue_event('1, '1, 1'b1);
    queue_event('0, '0, 1'b1);
    queue_event('0, '0, 1'b0);
    queue_event('1, '1, 1'b0);
    queue_event('0, 63'd100, 1'b0);
    queue_event('0, 63'd50000101, 1'b0);
    queue_event('0, 63'd0, 1'b0);
    queue_event('0, 63'd50000101, 1'b0);
    queue_event(32'h5555_AAAA, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0);
    queue_event(32'hAAAA_5555, 63'h5555_5555_5555_5555, 1'b0);

    // Small thresholds: allow, warn, allow, then repeated blocks, then expiry
    set_regs(40'd1000, 32'd2, 32'd3);
    repeat (6) queue_event(32'h1234_5678, 63'd1000, 1'b0);
    queue_event(32'h1234_5678, 63'd2000, 1'b0);
    queue_event(32'h1234_5678, 63'd3001, 1'b0);

    run_phase(40'd50000000, 32'd10, 32'd50, 2, 154, 30);
    run_phase(40'd1, 32'd1, 32'd1, 8, 154, 0);
    run_phase(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 40, 154, 30);
    run_phase(40'd1000, 32'd3, 32'd6, 5, 154, 60);
    run_phase(40'd0, 32'd0, 32'd0, 4, 154, 20);
    run_phase(40'd200, 32'd6, 32'd4, 3, 154, 30);
    run_phase(WL_W'($urandom_range(1 << 20, 1)), $urandom_range(12, 1),
              $urandom_range(20, 1), 12, 154, 30);
    run_phase(40'd500000, 32'd2, 32'd20, 33, 154, 10);

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("per_key_write_rate_monitor_tb OK");
    else
      $display("per_key_write_rate_monitor_tb NOT OK");
    $finish;
  end

  // Stop a hung run
  initial begin
    #8_000_000;
    $display("per_key_write_rate_monitor_tb NOT OK");
    $finish;
  end

endmodule
